### rtl/rbu_pkg.sv
package rbu_pkg;

	// Blend equation codes.
	localparam logic [2:0] EQ_ADD  = 3'd0;
	localparam logic [2:0] EQ_SUB  = 3'd1;
	localparam logic [2:0] EQ_RSUB = 3'd2;
	localparam logic [2:0] EQ_MIN  = 3'd3;
	localparam logic [2:0] EQ_MAX  = 3'd4;

	// Blend factor modes, shared by the source and destination weights.
	localparam logic [3:0] FM_ZERO          = 4'd0;
	localparam logic [3:0] FM_ONE           = 4'd1;
	localparam logic [3:0] FM_SRC_COLOR     = 4'd2;
	localparam logic [3:0] FM_INV_SRC_COLOR = 4'd3;
	localparam logic [3:0] FM_DST_COLOR     = 4'd4;
	localparam logic [3:0] FM_INV_DST_COLOR = 4'd5;
	localparam logic [3:0] FM_SRC_ALPHA     = 4'd6;
	localparam logic [3:0] FM_INV_SRC_ALPHA = 4'd7;
	localparam logic [3:0] FM_DST_ALPHA     = 4'd8;
	localparam logic [3:0] FM_INV_DST_ALPHA = 4'd9;

	// Configuration register indexes and port widths.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_EQUATION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_FACTOR = 2'd2;

	typedef struct packed {
		logic [2:0] equation;
		logic [3:0] src_mode;
		logic [3:0] dst_mode;
	} rbu_cfg_t;

	localparam rbu_cfg_t CFG_RESET = '{equation: EQ_ADD, src_mode: FM_ONE, dst_mode: FM_ZERO};

endpackage

### rtl/rbu_term.sv
// One weighted term: picks the blend factor for a channel and forms the
// rounded normalized product weighted * factor / M.
module rbu_term #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic [3:0]              mode,
	input  logic [CHANNEL_BITS-1:0] weighted,
	input  logic [CHANNEL_BITS-1:0] src_chan,
	input  logic [CHANNEL_BITS-1:0] dst_chan,
	input  logic [CHANNEL_BITS-1:0] src_a_chan,
	input  logic [CHANNEL_BITS-1:0] dst_a_chan,
	output logic [CHANNEL_BITS-1:0] term
);

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned PW = 2 * CB + 1;
	localparam logic [CB-1:0] CH_MAX = {CB{1'b1}};
	localparam logic [PW-1:0] CH_HALF = PW'(CH_MAX >> 1);

	logic [CB-1:0] factor;
	logic [PW-1:0] prod;
	logic [PW-1:0] quot;

	always_comb begin
		unique case (mode)
			rbu_pkg::FM_ZERO:          factor = '0;
			rbu_pkg::FM_ONE:           factor = CH_MAX;
			rbu_pkg::FM_SRC_COLOR:     factor = src_chan;
			rbu_pkg::FM_INV_SRC_COLOR: factor = CH_MAX - src_chan;
			rbu_pkg::FM_DST_COLOR:     factor = dst_chan;
			rbu_pkg::FM_INV_DST_COLOR: factor = CH_MAX - dst_chan;
			rbu_pkg::FM_SRC_ALPHA:     factor = src_a_chan;
			rbu_pkg::FM_INV_SRC_ALPHA: factor = CH_MAX - src_a_chan;
			rbu_pkg::FM_DST_ALPHA:     factor = dst_a_chan;
			rbu_pkg::FM_INV_DST_ALPHA: factor = CH_MAX - dst_a_chan;
			default:                   factor = '0;
		endcase
	end

	// Division by 2^CB - 1 of a value below 2^(2*CB) is exact as
	// (x + (x >> CB) + 1) >> CB.
	always_comb begin
		prod = PW'(weighted) * PW'(factor) + CH_HALF;
		quot = (prod + (prod >> CB) + PW'(1)) >> CB;
		term = quot[CB-1:0];
	end

endmodule

### rtl/rbu_combine.sv
// Combines the two weighted terms of one channel by the blend equation,
// saturating to 0..M.
module rbu_combine #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic [2:0]              equation,
	input  logic [CHANNEL_BITS-1:0] src_term,
	input  logic [CHANNEL_BITS-1:0] dst_term,
	output logic [CHANNEL_BITS-1:0] result
);

	localparam int unsigned CB = CHANNEL_BITS;

	logic [CB:0] sum;
	logic        src_gt;

	always_comb begin
		sum    = {1'b0, src_term} + {1'b0, dst_term};
		src_gt = src_term > dst_term;
		unique case (equation)
			rbu_pkg::EQ_ADD:  result = sum[CB] ? {CB{1'b1}} : sum[CB-1:0];
			rbu_pkg::EQ_SUB:  result = src_gt ? src_term - dst_term : '0;
			rbu_pkg::EQ_RSUB: result = (dst_term > src_term) ? dst_term - src_term : '0;
			rbu_pkg::EQ_MIN:  result = (src_term < dst_term) ? src_term : dst_term;
			rbu_pkg::EQ_MAX:  result = src_gt ? src_term : dst_term;
			default:          result = '0;
		endcase
	end

endmodule

### rtl/rgba_blend_unit.sv
// RGBA blend unit.
// The slave stream carries one source pixel and one destination pixel per
// transfer; the master stream returns the blended pixel. Each channel is
// an unsigned normalized value of CHANNEL_BITS bits, where all ones is 1.0.
// The blend function and equation are set through the configuration write
// channel (index 0 equation, 1 source factor, 2 destination factor). The
// configuration channel is always ready, and it should only be written
// while no pixel is in flight.
// The datapath has two register stages: the input register and the output
// register. Between them a single combinational pass selects the factors,
// forms the rounded products and combines the two terms of each channel.
// Pixels pass from the input to the output register, which drives the master
// side; one pixel is accepted every cycle while the receiver keeps up.
// When the receiver stalls, the input register still fills if the output
// register is free, so up to two pixels are held before s_axis_tready drops.
// Reset clears every stage's valid flag and restores the configuration to
// add, source factor one, destination factor zero.
module rgba_blend_unit #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbu_pkg::CFG_DATA_W-1:0]  cfg_data,

	// From the lowest bit up: src_red, src_green, src_blue, src_alpha,
	// dst_red, dst_green, dst_blue, dst_alpha.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [8*CHANNEL_BITS-1:0]       s_axis_tdata,

	// From the lowest bit up: out_red, out_green, out_blue, out_alpha,
	// then zero fill up to a whole byte.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned OUT_W = ((4 * CB + 7) / 8) * 8;

	rbu_pkg::rbu_cfg_t cfg_q;

	logic          s1_valid;
	logic [CB-1:0] src_s1 [4];
	logic [CB-1:0] dst_s1 [4];

	logic [CB-1:0] src_term [4];
	logic [CB-1:0] dst_term [4];
	logic [CB-1:0] blended  [4];

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic [OUT_W-1:0] out_data_next;

	logic out_ready;
	logic s1_ready;

	// Configuration register file. Writes to an index beyond the list are
	// accepted and dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rbu_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbu_pkg::CFG_EQUATION:   cfg_q.equation <= cfg_data[2:0];
				rbu_pkg::CFG_SRC_FACTOR: cfg_q.src_mode <= cfg_data;
				rbu_pkg::CFG_DST_FACTOR: cfg_q.dst_mode <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage advances when it is empty or the stage after it moves on.
	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s1_ready      = !s1_valid || out_ready;
	assign s_axis_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid <= s_axis_tvalid;
			end
			if (out_ready) begin
				out_valid_q <= s1_valid;
			end
		end
	end

	// Stage 1: input pixel pair.
	always_ff @(posedge clk) begin
		if (s1_ready && s_axis_tvalid) begin
			for (int c = 0; c < 4; c++) begin
				src_s1[c] <= s_axis_tdata[c*CB +: CB];
				dst_s1[c] <= s_axis_tdata[(c+4)*CB +: CB];
			end
		end
	end

	// Factor selection, rounded products and the blend equation for every
	// channel.
	for (genvar c = 0; c < 4; c++) begin : g_chan
		rbu_term #(.CHANNEL_BITS(CB)) u_src_term (
			.mode       (cfg_q.src_mode),
			.weighted   (src_s1[c]),
			.src_chan   (src_s1[c]),
			.dst_chan   (dst_s1[c]),
			.src_a_chan (src_s1[3]),
			.dst_a_chan (dst_s1[3]),
			.term       (src_term[c])
		);

		rbu_term #(.CHANNEL_BITS(CB)) u_dst_term (
			.mode       (cfg_q.dst_mode),
			.weighted   (dst_s1[c]),
			.src_chan   (src_s1[c]),
			.dst_chan   (dst_s1[c]),
			.src_a_chan (src_s1[3]),
			.dst_a_chan (dst_s1[3]),
			.term       (dst_term[c])
		);

		rbu_combine #(.CHANNEL_BITS(CB)) u_combine (
			.equation (cfg_q.equation),
			.src_term (src_term[c]),
			.dst_term (dst_term[c]),
			.result   (blended[c])
		);
	end

	// Output register, packed with zero fill in the top bits.
	always_comb begin
		out_data_next = '0;
		for (int c = 0; c < 4; c++) begin
			out_data_next[c*CB +: CB] = blended[c];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s1_valid) begin
			out_data_q <= out_data_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

### rtl/rbu_checker.sv
// Port-level checks for the blend unit.
module rbu_checker #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata
);

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] inflight_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// Pixels accepted but not yet delivered; the pipeline holds at most two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 2'd0)
		else $error("result shown with no pixel in flight");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 2'd2 && !out_xfer |-> !in_xfer)
		else $error("pixel accepted with the pipeline full");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage is empty");

endmodule

bind rgba_blend_unit rbu_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_rbu_checker (.*);

### bench/testbench.sv
module testbench;

	// Channel geometry of the instance under test.
	localparam int unsigned CH_BITS = 8;
	localparam int unsigned IN_W = 8 * CH_BITS;
	localparam int unsigned OUT_W = ((4 * CH_BITS + 7) / 8) * 8;
	localparam logic [7:0] CH_MAX = 8'hFF;
	localparam logic [7:0] CH_HALF = 8'd127;

	// Widths of the configuration channel.
	localparam int unsigned CFG_IDX_W = rbu_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W = rbu_pkg::CFG_DATA_W;

	// Codes that the package leaves unnamed: the unused equations, the unused
	// factor modes and the register index that lies past the last register.
	localparam logic [2:0] EQ_UNUSED_HI = 3'd7;
	localparam logic [3:0] FM_UNUSED_HI = 4'd15;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;

	// Bit 3 of the configuration data is dropped by the 3-bit equation register.
	localparam logic [CFG_DATA_W-1:0] CFG_EQ_HIGH_BIT = 4'b1000;

	// A stall-free run never goes this many cycles without a transfer; the
	// longest planned pause is the receiver hold-off below.
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 24;
	localparam int PHASE_PIXELS = 50;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_PATTERN,
		RX_SPARSE
	} rx_style_t;

	localparam string CH_NAME [4] = '{"red", "green", "blue", "alpha"};

	logic clk;
	logic arst_n;

	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// From the lowest bit up: src_red, src_green, src_blue, src_alpha,
	// dst_red, dst_green, dst_blue, dst_alpha.
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;

	// From the lowest bit up: out_red, out_green, out_blue, out_alpha.
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;

	// Our own copy of the blend configuration, updated on every register
	// transfer exactly as the hardware is meant to update its registers.
	logic [2:0] cur_equation;
	logic [3:0] cur_src_mode;
	logic [3:0] cur_dst_mode;

	// Blended pixels that have been predicted but not yet seen on the output.
	logic [OUT_W-1:0] pending_pixels [$];
	int errors;

	rx_style_t rx_style;
	int hold_left;

	rgba_blend_unit #(
		.CHANNEL_BITS(CH_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Blend predictor.
	// ------------------------------------------------------------------

	// Normalized product: 255 stands for 1.0, so a*b is divided by 255 with
	// rounding to nearest.
	function automatic logic [7:0] scale_unorm(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] prod;
		prod = a * b + CH_HALF;
		return 8'(prod / CH_MAX);
	endfunction

	// Per-channel weight for one factor mode. Modes past the last defined one
	// weigh the term with zero.
	function automatic logic [7:0] weight_for(input logic [3:0] mode,
			input logic [3:0][7:0] src, input logic [3:0][7:0] dst, input int ch);
		case (mode)
			rbu_pkg::FM_ZERO:          return '0;
			rbu_pkg::FM_ONE:           return CH_MAX;
			rbu_pkg::FM_SRC_COLOR:     return src[ch];
			rbu_pkg::FM_INV_SRC_COLOR: return CH_MAX - src[ch];
			rbu_pkg::FM_DST_COLOR:     return dst[ch];
			rbu_pkg::FM_INV_DST_COLOR: return CH_MAX - dst[ch];
			rbu_pkg::FM_SRC_ALPHA:     return src[3];
			rbu_pkg::FM_INV_SRC_ALPHA: return CH_MAX - src[3];
			rbu_pkg::FM_DST_ALPHA:     return dst[3];
			rbu_pkg::FM_INV_DST_ALPHA: return CH_MAX - dst[3];
			default:                   return '0;
		endcase
	endfunction

	// Blended pixel under the current configuration. Min and max compare the
	// weighted terms, and an unused equation yields a black, transparent pixel.
	function automatic logic [OUT_W-1:0] blend_pixel(input logic [IN_W-1:0] px);
		logic [3:0][7:0] src;
		logic [3:0][7:0] dst;
		logic [7:0] ts;
		logic [7:0] td;
		logic [8:0] sum;
		logic [OUT_W-1:0] res;
		src = px[31:0];
		dst = px[63:32];
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			ts = scale_unorm(src[ch], weight_for(cur_src_mode, src, dst, ch));
			td = scale_unorm(dst[ch], weight_for(cur_dst_mode, src, dst, ch));
			case (cur_equation)
				rbu_pkg::EQ_ADD: begin
					sum = ts + td;
					res[8*ch +: 8] = (sum > CH_MAX) ? CH_MAX : sum[7:0];
				end
				rbu_pkg::EQ_SUB:  res[8*ch +: 8] = (ts > td) ? ts - td : 8'd0;
				rbu_pkg::EQ_RSUB: res[8*ch +: 8] = (td > ts) ? td - ts : 8'd0;
				rbu_pkg::EQ_MIN:  res[8*ch +: 8] = (ts < td) ? ts : td;
				rbu_pkg::EQ_MAX:  res[8*ch +: 8] = (ts > td) ? ts : td;
				default:          res[8*ch +: 8] = 8'd0;
			endcase
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers. All of them are entered just after a falling edge
	// and return just after a falling edge.
	// ------------------------------------------------------------------

	function automatic logic [IN_W-1:0] make_px(input logic [7:0] sr, input logic [7:0] sg,
			input logic [7:0] sb, input logic [7:0] sa, input logic [7:0] dr,
			input logic [7:0] dg, input logic [7:0] db, input logic [7:0] da);
		return {da, db, dg, dr, sa, sb, sg, sr};
	endfunction

	// Channel values lean toward the corners and the middle of the range, where
	// rounding and saturation are most likely to go wrong.
	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return CH_MAX;
			2: return 8'($urandom_range(0, 3));
			3: return 8'($urandom_range(252, 255));
			4: return 8'($urandom_range(125, 130));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] random_pixel();
		logic [IN_W-1:0] px;
		for (int i = 0; i < 8; i++)
			px[8*i +: 8] = random_channel();
		return px;
	endfunction

	// One register transfer. The shadow copy only changes once the transfer
	// has actually happened.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rbu_pkg::CFG_EQUATION:   cur_equation = data[2:0];
			rbu_pkg::CFG_SRC_FACTOR: cur_src_mode = data;
			rbu_pkg::CFG_DST_FACTOR: cur_dst_mode = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offers one pixel and waits for its transfer. Valid is left high so that
	// back-to-back calls give a gapless burst; the caller drops it for a gap.
	task automatic send_pixel(input logic [IN_W-1:0] px);
		s_axis_tdata = px;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_pixels.push_back(blend_pixel(px));
		@(negedge clk);
	endtask

	// A stream of random pixels, optionally broken into bursts of random
	// length with random gaps. The data bus carries junk during the gaps.
	task automatic send_stream(input int count, input bit with_gaps);
		int burst;
		burst = $urandom_range(1, 16);
		for (int i = 0; i < count; i++) begin
			send_pixel(random_pixel());
			burst--;
			if (with_gaps && burst == 0) begin
				s_axis_tvalid = 1'b0;
				s_axis_tdata = {$urandom, $urandom};
				repeat ($urandom_range(1, 12))
					@(negedge clk);
				burst = $urandom_range(1, 16);
			end
		end
		s_axis_tvalid = 1'b0;
	endtask

	// Waits until every predicted pixel has come out, then lets the pipeline
	// settle so that the block is idle before the next register write.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Out of reset the blend is add with weights one and zero, so the source
	// pixel passes through unchanged.
	task automatic test_reset_defaults();
		send_pixel(make_px(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_pixel(make_px(CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX, CH_MAX));
		drain();
	endtask

	// Every equation, the unused ones included, under the classic
	// source-alpha over blend. The last case sets the bit above the
	// equation field, which the register must drop.
	task automatic test_equations();
		logic [IN_W-1:0] px;
		px = make_px(8'd200, 8'd60, CH_MAX, 8'd180, 8'd90, 8'd250, 8'd0, 8'd128);
		write_reg(rbu_pkg::CFG_SRC_FACTOR, rbu_pkg::FM_SRC_ALPHA);
		write_reg(rbu_pkg::CFG_DST_FACTOR, rbu_pkg::FM_INV_SRC_ALPHA);
		for (int eq = rbu_pkg::EQ_ADD; eq <= EQ_UNUSED_HI; eq++) begin
			write_reg(rbu_pkg::CFG_EQUATION, CFG_DATA_W'(eq));
			send_pixel(px);
			drain();
		end
		write_reg(rbu_pkg::CFG_EQUATION, CFG_EQ_HIGH_BIT | CFG_DATA_W'(rbu_pkg::EQ_SUB));
		send_pixel(px);
		drain();
	endtask

	// Every factor mode on both sides at once: the source side walks up
	// through all sixteen codes while the destination side walks down, so
	// the unused modes are seen on each side.
	task automatic test_factor_modes();
		logic [IN_W-1:0] px;
		px = make_px(8'd200, 8'd60, CH_MAX, 8'd180, 8'd90, 8'd250, 8'd0, 8'd128);
		write_reg(rbu_pkg::CFG_EQUATION, CFG_DATA_W'(rbu_pkg::EQ_ADD));
		for (int m = rbu_pkg::FM_ZERO; m <= FM_UNUSED_HI; m++) begin
			write_reg(rbu_pkg::CFG_SRC_FACTOR, CFG_DATA_W'(m));
			write_reg(rbu_pkg::CFG_DST_FACTOR, FM_UNUSED_HI - CFG_DATA_W'(m));
			send_pixel(px);
			drain();
		end
	endtask

	// A write to the index past the last register must leave all three
	// registers as they are.
	task automatic test_unknown_index();
		write_reg(rbu_pkg::CFG_EQUATION, CFG_DATA_W'(rbu_pkg::EQ_RSUB));
		write_reg(rbu_pkg::CFG_SRC_FACTOR, rbu_pkg::FM_DST_COLOR);
		write_reg(rbu_pkg::CFG_DST_FACTOR, rbu_pkg::FM_INV_DST_ALPHA);
		write_reg(CFG_IDX_NONE, '1);
		send_pixel(make_px(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
		drain();
	endtask

	// Random phases, each with its own configuration and its own idling on
	// both sides. Some phases set every register to all zeros or all ones;
	// the rest mostly use defined codes with an occasional unused one.
	task automatic test_random_blend();
		logic [CFG_DATA_W-1:0] eq_val;
		logic [CFG_DATA_W-1:0] src_val;
		logic [CFG_DATA_W-1:0] dst_val;
		bit with_gaps;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0: begin
					eq_val = '0;
					src_val = '0;
					dst_val = '0;
				end
				1: begin
					eq_val = '1;
					src_val = '1;
					dst_val = '1;
				end
				default: begin
					eq_val = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) :
						CFG_DATA_W'($urandom_range(rbu_pkg::EQ_ADD, rbu_pkg::EQ_MAX));
					src_val = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom) :
						CFG_DATA_W'($urandom_range(rbu_pkg::FM_ZERO,
							rbu_pkg::FM_INV_DST_ALPHA));
					dst_val = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom) :
						CFG_DATA_W'($urandom_range(rbu_pkg::FM_ZERO,
							rbu_pkg::FM_INV_DST_ALPHA));
				end
			endcase
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_NONE, CFG_DATA_W'($urandom));
			write_reg(rbu_pkg::CFG_EQUATION, eq_val);
			write_reg(rbu_pkg::CFG_SRC_FACTOR, src_val);
			write_reg(rbu_pkg::CFG_DST_FACTOR, dst_val);

			// The first phase runs with no idling at all on either side.
			if (phase == 0) begin
				rx_style = RX_ALWAYS;
				with_gaps = 1'b0;
			end else begin
				rx_style = rx_style_t'($urandom_range(RX_ALWAYS, RX_SPARSE));
				with_gaps = ($urandom_range(0, 3) != 0);
			end
			send_stream(PHASE_PIXELS, with_gaps);
			drain();
		end
		rx_style = RX_ALWAYS;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering pixels without a gap, so every pipeline stage fills and the
	// input side has to stall. Once the hold ends everything must drain in
	// order.
	task automatic test_backpressure();
		write_reg(rbu_pkg::CFG_EQUATION, CFG_DATA_W'(rbu_pkg::EQ_MAX));
		write_reg(rbu_pkg::CFG_SRC_FACTOR, rbu_pkg::FM_INV_DST_COLOR);
		write_reg(rbu_pkg::CFG_DST_FACTOR, rbu_pkg::FM_SRC_COLOR);
		rx_style = RX_ALWAYS;
		hold_left = HOLD_OFF_CYCLES;
		send_stream(40, 1'b0);
		drain();
	endtask

	// ------------------------------------------------------------------
	// Receiver. It changes ready at the falling edge. A pending hold-off
	// wins over the current style and is counted down here.
	// ------------------------------------------------------------------
	initial begin : receiver
		logic [15:0] rx_pattern;
		logic [3:0] rx_slot;
		rx_pattern = '1;
		rx_slot = '0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				case (rx_style)
					RX_ALWAYS: m_axis_tready = 1'b1;
					RX_PATTERN: begin
						if (rx_slot == 0)
							rx_pattern = 16'($urandom);
						m_axis_tready = rx_pattern[rx_slot];
						rx_slot++;
					end
					default: m_axis_tready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Output checker. Each transfer on the master side is compared channel
	// by channel against the oldest predicted pixel.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_output
		logic [OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: blended pixel %h arrived with none expected",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				for (int ch = 0; ch < 4; ch++) begin
					if (m_axis_tdata[8*ch +: 8] !== want[8*ch +: 8]) begin
						$display("%0t: out_%s mismatch: expected %0d, actual %0d",
							$time, CH_NAME[ch], want[8*ch +: 8], m_axis_tdata[8*ch +: 8]);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog. Any transfer on any channel restarts the count.
	// ------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d pixels outstanding",
					$time, idle_cycles, pending_pixels.size());
				$display("rgba_blend_unit test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rbu_pkg::CFG_EQUATION;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur_equation = rbu_pkg::CFG_RESET.equation;
		cur_src_mode = rbu_pkg::CFG_RESET.src_mode;
		cur_dst_mode = rbu_pkg::CFG_RESET.dst_mode;
		rx_style = RX_ALWAYS;
		hold_left = 0;
		errors = 0;

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_equations();
		test_factor_modes();
		test_unknown_index();
		test_random_blend();
		test_backpressure();

		// The last drain has already waited out the pipeline.
		drain();
		if (errors == 0)
			$display("rgba_blend_unit test passed");
		else
			$display("rgba_blend_unit test failed");
		$finish;
	end

endmodule
